@@ hdl/bgls_pkg.sv @@
// shared constants and helpers for the battery gauge led sequencer
`timescale 1ns / 1ps
`default_nettype none
package bgls_pkg;

  localparam int PctW  = 7;
  localparam int LedW  = 5;
  localparam int LvlW  = 3;
  localparam int TickW = 13;
  localparam int NumThr = 5;

  localparam logic [TickW-1:0] TickMax  = 13'd8191;
  localparam logic [TickW-1:0] TickS0   = 13'd1;
  localparam logic [TickW-1:0] TickS1   = 13'd150;
  localparam logic [TickW-1:0] TickS2   = 13'd300;
  localparam logic [TickW-1:0] TickS3   = 13'd450;
  localparam logic [TickW-1:0] TickS4   = 13'd600;
  localparam logic [TickW-1:0] TickOff0 = 13'd750;
  localparam logic [TickW-1:0] TickShow = 13'd1000;
  localparam logic [TickW-1:0] TickOff1 = 13'd2000;
  localparam logic [TickW-1:0] TickWrap = 13'd5000;

  // register indexes
  localparam logic [2:0] RegThr1 = 3'd0;
  localparam logic [2:0] RegThr2 = 3'd1;
  localparam logic [2:0] RegThr3 = 3'd2;
  localparam logic [2:0] RegThr4 = 3'd3;
  localparam logic [2:0] RegThr5 = 3'd4;

  localparam logic [PctW-1:0] Thr1Rst = 7'd10;
  localparam logic [PctW-1:0] Thr2Rst = 7'd30;
  localparam logic [PctW-1:0] Thr3Rst = 7'd50;
  localparam logic [PctW-1:0] Thr4Rst = 7'd70;
  localparam logic [PctW-1:0] Thr5Rst = 7'd90;

  typedef logic [PctW-1:0] pct_t;
  typedef logic [LedW-1:0] led_t;
  typedef logic [LvlW-1:0] lvl_t;
  typedef logic [TickW-1:0] tick_t;

  // n lit leds as a thermometer code, clipped at five
  function automatic led_t thermo(input lvl_t n);
    led_t r;
    unique case (n)
      3'd0: r = 5'b00000;
      3'd1: r = 5'b00001;
      3'd2: r = 5'b00011;
      3'd3: r = 5'b00111;
      3'd4: r = 5'b01111;
      default: r = 5'b11111;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/battery_gauge_led_sequencer.sv @@
// Five-LED battery charge bar: one transaction per millisecond tick.
//
// Input channel (in_valid / in_stall) carries the charge percent and the
// discharging, charging and heating flags of one tick. Output channel
// (out_valid / out_stall) returns the LED thermometer code and the bar
// level for that tick, one result per input transaction.
// The five level thresholds sit on an APB-style port at byte addresses
// 0x00..0x10 and may be read back; write them only while the block is idle.
//
// The output register loads a tick's result at the edge that accepts it.
// Throughput is one tick per cycle unless a result waits on out_stall; the
// level compare, tick counter and LED update are combinational.
// A new tick is taken while the previous result is being taken, so
// in_stall only rises when a result is waiting and out_stall is high.
//
// Reset (rst_n low, synchronous) clears the tick counter, turns all LEDs
// off, empties the output register and loads the default thresholds
// 10, 30, 50, 70 and 90 percent.
`timescale 1ns / 1ps
`default_nettype none
module battery_gauge_led_sequencer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [6:0] in_charge_percent,
  input  wire logic       in_discharging,
  input  wire logic       in_charging,
  input  wire logic       in_heating,
  // result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [4:0]      out_leds_lit,
  output logic [2:0]      out_charge_level,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  bgls_pkg::pct_t  thr_r [bgls_pkg::NumThr];
  bgls_pkg::tick_t tick_cnt_r, tick_cnt_nxt, tick_inc;
  bgls_pkg::led_t  led_r, led_nxt, sweep_led;
  bgls_pkg::lvl_t  lvl_r, lvl_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            in_fire;
  logic            cfg_wr;
  logic [2:0]      cfg_idx;
  logic            mode_dsg, mode_chg, mode_idle;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r[0] <= bgls_pkg::Thr1Rst;
      thr_r[1] <= bgls_pkg::Thr2Rst;
      thr_r[2] <= bgls_pkg::Thr3Rst;
      thr_r[3] <= bgls_pkg::Thr4Rst;
      thr_r[4] <= bgls_pkg::Thr5Rst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        bgls_pkg::RegThr1: thr_r[0] <= pwdata[6:0];
        bgls_pkg::RegThr2: thr_r[1] <= pwdata[6:0];
        bgls_pkg::RegThr3: thr_r[2] <= pwdata[6:0];
        bgls_pkg::RegThr4: thr_r[3] <= pwdata[6:0];
        bgls_pkg::RegThr5: thr_r[4] <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      bgls_pkg::RegThr1: prdata = {25'd0, thr_r[0]};
      bgls_pkg::RegThr2: prdata = {25'd0, thr_r[1]};
      bgls_pkg::RegThr3: prdata = {25'd0, thr_r[2]};
      bgls_pkg::RegThr4: prdata = {25'd0, thr_r[3]};
      bgls_pkg::RegThr5: prdata = {25'd0, thr_r[4]};
      default:           prdata = 32'd0;
    endcase
  end

  // output register frees up when empty or being taken
  assign in_stall  = out_valid_r && out_stall;
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_leds_lit     = led_r;
  assign out_charge_level = lvl_r;

  assign mode_dsg  = in_discharging && !in_charging && !in_heating;
  assign mode_chg  = !in_discharging && in_charging && !in_heating;
  assign mode_idle = !in_discharging && !in_charging && !in_heating;

  // first threshold not reached, in order
  always_comb begin
    priority if (in_charge_percent < thr_r[0]) lvl_nxt = 3'd0;
    else if (in_charge_percent < thr_r[1])     lvl_nxt = 3'd1;
    else if (in_charge_percent < thr_r[2])     lvl_nxt = 3'd2;
    else if (in_charge_percent < thr_r[3])     lvl_nxt = 3'd3;
    else if (in_charge_percent < thr_r[4])     lvl_nxt = 3'd4;
    else                                       lvl_nxt = 3'd5;
  end

  assign tick_inc = (tick_cnt_r == bgls_pkg::TickMax) ? tick_cnt_r
                                                      : tick_cnt_r + 13'd1;

  // sweep step leds: falling 5..1, rising 1..5
  always_comb begin
    sweep_led = led_r;
    unique case (tick_inc)
      bgls_pkg::TickS0: sweep_led = bgls_pkg::thermo(mode_dsg ? 3'd5 : 3'd1);
      bgls_pkg::TickS1: sweep_led = bgls_pkg::thermo(mode_dsg ? 3'd4 : 3'd2);
      bgls_pkg::TickS2: sweep_led = bgls_pkg::thermo(3'd3);
      bgls_pkg::TickS3: sweep_led = bgls_pkg::thermo(mode_dsg ? 3'd2 : 3'd4);
      bgls_pkg::TickS4: sweep_led = bgls_pkg::thermo(mode_dsg ? 3'd1 : 3'd5);
      bgls_pkg::TickOff0, bgls_pkg::TickOff1: sweep_led = '0;
      bgls_pkg::TickShow: sweep_led = bgls_pkg::thermo(lvl_nxt);
      default: sweep_led = led_r;
    endcase
  end

  always_comb begin
    tick_cnt_nxt  = tick_cnt_r;
    led_nxt       = led_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
      tick_cnt_nxt  = tick_inc;
      if (mode_dsg || mode_chg) begin
        led_nxt = sweep_led;
        if (tick_inc == bgls_pkg::TickWrap) tick_cnt_nxt = '0;
      end else if (mode_idle) begin
        led_nxt      = bgls_pkg::thermo(lvl_nxt);
        tick_cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_cnt_r  <= '0;
      led_r       <= '0;
      lvl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tick_cnt_r  <= tick_cnt_nxt;
      led_r       <= led_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_fire) lvl_r <= lvl_nxt;
    end
  end

  // checks
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_charge_level <= 3'd5))
    else $error("charge level out of range");

  a_thermo_code: assert property (@(posedge clk) disable iff (!rst_n)
    ((out_leds_lit & (out_leds_lit + 5'd1)) == 5'd0))
    else $error("led pattern is not a thermometer code");

  a_idle_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && mode_idle) |=> (tick_cnt_r == '0))
    else $error("idle tick did not clear the counter");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled while output register empty");

endmodule
`default_nettype wire

@@ sim/tb.sv @@
// self-checking testbench for the battery gauge led sequencer
`timescale 1ns / 1ps
module tb;

  localparam int LongHold    = 300;
  localparam int WatchLimit  = 2000;
  localparam int DrainCycles = 3;
  localparam int PhaseTicks  = 30;
  localparam logic [2:0] RegSpareLo = 3'd5;
  localparam logic [2:0] RegSpareHi = 3'd7;

  typedef struct packed {
    bgls_pkg::pct_t pct;
    logic dsg;
    logic chg;
    logic heat;
  } tick_item_t;

  typedef struct packed {
    bgls_pkg::led_t leds;
    bgls_pkg::lvl_t level;
  } bar_display_t;

  typedef enum int {ModeIdle, ModeDsg, ModeChg, ModeHeld, ModeNoise} tick_mode_t;
  typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_t;
  typedef enum int {
    SetDefault, SetZero, SetMax, SetSpan, SetAscending, SetUnordered
  } thr_setting_t;

  logic           clk;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  bgls_pkg::pct_t in_charge_percent = '0;
  logic           in_discharging = 1'b0;
  logic           in_charging = 1'b0;
  logic           in_heating = 1'b0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  bgls_pkg::led_t out_leds_lit;
  bgls_pkg::lvl_t out_charge_level;
  logic           psel = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite = 1'b0;
  logic [4:0]     paddr = '0;
  logic [31:0]    pwdata = '0;
  logic [31:0]    prdata;
  logic           pready;

  battery_gauge_led_sequencer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_charge_percent(in_charge_percent), .in_discharging(in_discharging),
    .in_charging(in_charging), .in_heating(in_heating),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_leds_lit(out_leds_lit), .out_charge_level(out_charge_level),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // gauge model state
  bgls_pkg::pct_t  thr_model [bgls_pkg::NumThr];
  bgls_pkg::tick_t model_ticks = '0;
  bgls_pkg::lvl_t  model_lvl = '0;
  bgls_pkg::led_t  model_leds = '0;

  tick_item_t   tick_q[$];
  bar_display_t bar_display_q[$];
  int ticks_queued = 0;
  int ticks_taken = 0;
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req_seq = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bgls_pkg::led_t bar_code(input int n);
    return bgls_pkg::led_t'((1 << n) - 1);
  endfunction

  function automatic bgls_pkg::led_t sweep_code(input int step, input logic falling);
    return bar_code(falling ? 5 - step : step + 1);
  endfunction

  // one millisecond tick of the gauge: level, counter, then the led update
  task automatic advance_gauge(input tick_item_t t);
    bgls_pkg::lvl_t lvl;
    logic single;
    lvl = 3'd5;
    for (int k = bgls_pkg::NumThr - 1; k >= 0; k--) begin
      if (t.pct < thr_model[k]) lvl = bgls_pkg::lvl_t'(k);
    end
    model_lvl = lvl;
    if (model_ticks != bgls_pkg::TickMax) model_ticks = model_ticks + 13'd1;
    single = (t.dsg != t.chg) && !t.heat;
    if (single) begin
      case (model_ticks)
        bgls_pkg::TickS0:   model_leds = sweep_code(0, t.dsg);
        bgls_pkg::TickS1:   model_leds = sweep_code(1, t.dsg);
        bgls_pkg::TickS2:   model_leds = sweep_code(2, t.dsg);
        bgls_pkg::TickS3:   model_leds = sweep_code(3, t.dsg);
        bgls_pkg::TickS4:   model_leds = sweep_code(4, t.dsg);
        bgls_pkg::TickOff0: model_leds = '0;
        bgls_pkg::TickShow: model_leds = bar_code(int'(model_lvl));
        bgls_pkg::TickOff1: model_leds = '0;
        bgls_pkg::TickWrap: model_ticks = '0;
        default: ;
      endcase
    end else if (!t.dsg && !t.chg && !t.heat) begin
      model_leds = bar_code(int'(model_lvl));
      model_ticks = '0;
    end
    bar_display_q.push_back('{leds: model_leds, level: model_lvl});
  endtask

  // driver
  always @(posedge clk) begin : drive_ticks
    tick_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_gauge('{pct: in_charge_percent, dsg: in_discharging,
                        chg: in_charging, heat: in_heating});
        ticks_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (tick_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = tick_q.pop_front();
          in_valid <= 1'b1;
          in_charge_percent <= nxt.pct;
          in_discharging <= nxt.dsg;
          in_charging <= nxt.chg;
          in_heating <= nxt.heat;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  int hold_seen = 0;
  int hold_left = 0;
  always @(posedge clk) begin : check_results
    bar_display_t exp_d;
    if (rst_n) begin
      if (out_valid === 1'b1 && !out_stall) begin
        if (bar_display_q.size() == 0) begin
          $error("unexpected result: leds_lit %0d, charge_level %0d",
                 out_leds_lit, out_charge_level);
          fail_count++;
        end else begin
          exp_d = bar_display_q.pop_front();
          if (out_leds_lit !== exp_d.leds) begin
            $error("leds_lit: expected %0d, actual %0d", exp_d.leds, out_leds_lit);
            fail_count++;
          end
          if (out_charge_level !== exp_d.level) begin
            $error("charge_level: expected %0d, actual %0d", exp_d.level,
                   out_charge_level);
            fail_count++;
          end
        end
      end
      if (hold_seen != hold_req_seq) begin
        hold_seen = hold_req_seq;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // watchdog on cycles without any transaction
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst_n && !(in_valid && !in_stall) && !(out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles++;
      if (quiet_cycles >= WatchLimit) begin
        $display("FAIL");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
    end
  end

  task automatic cfg_write(input logic [4:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_read(input logic [4:0] addr, output logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [4:0] thr_addr(input int k);
    logic [2:0] r;
    case (k)
      0: r = bgls_pkg::RegThr1;
      1: r = bgls_pkg::RegThr2;
      2: r = bgls_pkg::RegThr3;
      3: r = bgls_pkg::RegThr4;
      default: r = bgls_pkg::RegThr5;
    endcase
    return {r, 2'b00};
  endfunction

  task automatic check_thresholds();
    logic [31:0] rd;
    for (int k = 0; k < bgls_pkg::NumThr; k++) begin
      cfg_read(thr_addr(k), rd);
      if (rd !== {25'd0, thr_model[k]}) begin
        $error("level%0d_threshold: expected %0d, actual %0d", k + 1, thr_model[k], rd);
        fail_count++;
      end
    end
  endtask

  task automatic apply_setting(input thr_setting_t s);
    bgls_pkg::pct_t v [bgls_pkg::NumThr];
    logic [31:0] w;
    int acc;
    acc = 0;
    for (int k = 0; k < bgls_pkg::NumThr; k++) begin
      case (s)
        SetDefault: v[k] = bgls_pkg::Thr1Rst + bgls_pkg::pct_t'(20 * k);
        SetZero:    v[k] = '0;
        SetMax:     v[k] = '1;
        SetSpan:    v[k] = bgls_pkg::pct_t'(25 * k);
        SetAscending: begin
          acc += $urandom_range(0, 20);
          v[k] = bgls_pkg::pct_t'(acc);
        end
        default:    v[k] = bgls_pkg::pct_t'($urandom_range(0, 127));
      endcase
      w = $urandom();
      w[bgls_pkg::PctW-1:0] = v[k];
      cfg_write(thr_addr(k), w);
      thr_model[k] = v[k];
    end
    // writes past the last threshold must leave everything alone
    cfg_write({3'($urandom_range(RegSpareHi, RegSpareLo)), 2'b00}, $urandom());
    check_thresholds();
  endtask

  task automatic set_idling(input idle_mode_t m);
    case (m)
      IdleNone:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IdleSender:   begin send_idle_pct = 87; recv_stall_pct = 0;  end
      IdleReceiver: begin send_idle_pct = 0;  recv_stall_pct = 87; end
      default:      begin send_idle_pct = 20; recv_stall_pct = 20; end
    endcase
  endtask

  // percent in 0..100 or near a threshold most of the time, above 100 now and then
  function automatic bgls_pkg::pct_t pick_pct();
    int r;
    bgls_pkg::pct_t p;
    r = $urandom_range(0, 99);
    if (r < 45) p = bgls_pkg::pct_t'($urandom_range(0, 100));
    else if (r < 60) p = bgls_pkg::pct_t'($urandom_range(101, 127));
    else p = thr_model[$urandom_range(0, bgls_pkg::NumThr - 1)]
             + bgls_pkg::pct_t'($urandom_range(0, 2)) - 7'd1;
    return p;
  endfunction

  function automatic tick_item_t make_tick(input tick_mode_t m);
    tick_item_t t;
    t.pct = pick_pct();
    t.dsg = 1'b0;
    t.chg = 1'b0;
    t.heat = 1'b0;
    case (m)
      ModeIdle: ;
      ModeDsg:  t.dsg = 1'b1;
      ModeChg:  t.chg = 1'b1;
      ModeHeld: begin
        if ($urandom_range(0, 4) == 0) begin
          t.dsg = 1'b1;
          t.chg = 1'b1;
        end else begin
          t.heat = 1'b1;
          t.dsg = 1'($urandom_range(0, 1));
          t.chg = 1'($urandom_range(0, 1));
        end
      end
      default: {t.dsg, t.chg, t.heat} = 3'($urandom_range(0, 7));
    endcase
    return t;
  endfunction

  task automatic push_tick(input bgls_pkg::pct_t p, input logic d, input logic c,
                           input logic h);
    tick_q.push_back('{pct: p, dsg: d, chg: c, heat: h});
    ticks_queued++;
  endtask

  task automatic push_run(input tick_mode_t m, input int len);
    for (int i = 0; i < len; i++) begin
      tick_q.push_back(make_tick(m));
      ticks_queued++;
    end
  endtask

  // mostly idle-then-sweep sequences, some with a heater blip, plus noise
  task automatic add_random_ticks(input int n);
    int made;
    int len;
    tick_mode_t m;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 9) < 7) begin
        push_run(ModeIdle, 1);
        m = $urandom_range(0, 1) ? ModeDsg : ModeChg;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(140, 460)
                                          : $urandom_range(1, 30);
        for (int i = 0; i < len; i++) begin
          push_run(($urandom_range(0, 19) == 0) ? ModeHeld : m, 1);
        end
        made += len + 1;
      end else begin
        len = $urandom_range(1, 20);
        push_run(ModeNoise, len);
        made += len;
      end
    end
  endtask

  task automatic wait_drained();
    while (ticks_taken != ticks_queued || bar_display_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin : run_test
    thr_setting_t s;
    thr_model[0] = bgls_pkg::Thr1Rst;
    thr_model[1] = bgls_pkg::Thr2Rst;
    thr_model[2] = bgls_pkg::Thr3Rst;
    thr_model[3] = bgls_pkg::Thr4Rst;
    thr_model[4] = bgls_pkg::Thr5Rst;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    check_thresholds();

    // directed: level boundaries at reset thresholds, then every mode
    set_idling(IdleNone);
    push_tick(7'd0,   1'b0, 1'b0, 1'b0);
    push_tick(7'd9,   1'b0, 1'b0, 1'b0);
    push_tick(7'd10,  1'b0, 1'b0, 1'b0);
    push_tick(7'd29,  1'b0, 1'b0, 1'b0);
    push_tick(7'd30,  1'b0, 1'b0, 1'b0);
    push_tick(7'd64,  1'b0, 1'b0, 1'b0);
    push_tick(7'd89,  1'b0, 1'b0, 1'b0);
    push_tick(7'd90,  1'b0, 1'b0, 1'b0);
    push_tick(7'd100, 1'b0, 1'b0, 1'b0);
    push_tick(7'd101, 1'b0, 1'b0, 1'b0);
    push_tick(7'd127, 1'b0, 1'b0, 1'b0);
    push_tick(7'd50,  1'b1, 1'b0, 1'b0);
    push_tick(7'd50,  1'b1, 1'b0, 1'b0);
    push_tick(7'd20,  1'b0, 1'b1, 1'b0);
    push_tick(7'd20,  1'b0, 1'b0, 1'b1);
    push_tick(7'd80,  1'b1, 1'b1, 1'b0);
    push_tick(7'd80,  1'b1, 1'b1, 1'b1);
    push_tick(7'd40,  1'b0, 1'b1, 1'b1);
    push_tick(7'd40,  1'b1, 1'b0, 1'b1);
    push_tick(7'd45,  1'b0, 1'b0, 1'b0);
    push_tick(7'd75,  1'b0, 1'b1, 1'b0);
    push_tick(7'd0,   1'b0, 1'b0, 1'b0);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: s = SetAscending;
        1: s = SetZero;
        2: s = SetMax;
        3: s = SetUnordered;
        4: s = SetSpan;
        5: s = SetUnordered;
        6: s = SetDefault;
        default: s = SetAscending;
      endcase
      apply_setting(s);
      set_idling(idle_mode_t'(ph % 4));
      add_random_ticks(PhaseTicks);
      wait_drained();
    end

    // receiver holds off while the sender keeps offering, block backs up
    apply_setting(SetAscending);
    set_idling(IdleNone);
    push_run(ModeIdle, 1);
    push_run(ModeDsg, 40);
    hold_req_seq++;
    wait_drained();
    // sender resumed only after every result came back
    push_run(ModeChg, 20);
    wait_drained();

    // long run: full falling schedule, held modes carry the counter on,
    // then the level shown at the 1000 tick of a rising run
    apply_setting(SetDefault);
    set_idling(IdleBoth);
    push_run(ModeIdle, 1);
    push_run(ModeDsg, 760);
    push_run(ModeHeld, 235);
    push_run(ModeChg, 10);
    push_run(ModeDsg, 5);
    push_run(ModeIdle, 2);
    wait_drained();

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
